@@ rtl/core/cdt_pkg.sv @@
// Shared types, constants and calendar helper functions for the
// calendar date/time counter. No dependencies.
`timescale 1ns / 1ps

package cdt_pkg;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned OUT_TUSER_W = 1;

  localparam logic [13:0] YEAR_LAST = 14'd9999;

  // Request kinds carried in the input tuser
  typedef enum logic [1:0] {
    REQ_FWD  = 2'd0,
    REQ_BACK = 2'd1,
    REQ_LOAD = 2'd2
  } req_e;

  // Date and time; year sits in the low bits, same as on the bus
  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } dt_t;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // floor(3*(m+1)/5) for the weekday sum, m in 0..15
  localparam logic [3:0] WD_MONTH_TERM [16] = '{
    4'd0, 4'd1, 4'd1, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
    4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd9, 4'd9
  };

  // Gregorian leap rule. y/100 by reciprocal, exact for y < 43690.
  function automatic logic leap_year(input logic [13:0] y);
    logic [27:0] prod;
    logic [8:0]  q;
    logic [13:0] r;
    prod = {14'd0, y} * 28'd5243;
    q    = prod[27:19];
    r    = y - 14'({5'd0, q} * 14'd100);
    return (y[1:0] == 2'b00) && ((r != 14'd0) || (q[1:0] == 2'b00));
  endfunction

  // Month length, zero for a month code outside 1..12
  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [3:0] idx;
    idx = m - 4'd1;
    if (m == 4'd0 || m > 4'd12) begin
      return 5'd0;
    end else if (m == 4'd2 && leap) begin
      return 5'd29;
    end else begin
      return MONTH_LEN[idx];
    end
  endfunction

endpackage

@@ rtl/core/calendar_date_time_counter_unit.sv @@
// Top level of the Gregorian calendar date/time counter.
// Depends on cdt_pkg, cdt_step, cdt_wday_sum and cdt_mod7.
`timescale 1ns / 1ps

// Keeps year/month/day and hour/minute/second. Each input transaction
// ticks one second forward (tuser 0), one second back (tuser 1) or loads
// the date and time from tdata (tuser 2); tuser 3 leaves the time as is.
// Carries go through days, months and years with the 4/100/400 leap rule;
// years wrap between 9999 and 0. A load with any field out of range
// (including a day past the end of its month) is dropped and the result
// carries load_error = 1. Every transaction yields exactly one result with
// the date/time after it and the weekday (0 = Monday). Reset state is
// 0001-01-01 00:00:00. One transaction is taken every cycle while the
// output side keeps up; each result passes through three register stages
// (snapshot, weekday sum, output register) on its way out. The counter
// registers update in the accept cycle; the two constant-reciprocal
// multiplies of the weekday (y/100, then mod 7) each get their own
// pipeline stage behind it.
module calendar_date_time_counter_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: load_year[13:0], load_month[17:14], load_day[22:18],
  //        load_hour[27:23], load_minute[33:28], load_second[39:34]
  input  logic [cdt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: req_type[1:0]
  input  logic [cdt_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: year_out[13:0], month_out[17:14], day_out[22:18],
  //        hour_out[27:23], minute_out[33:28], second_out[39:34],
  //        weekday[42:40], zero pad [47:43]
  output logic [cdt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: load_error[0]
  output logic [cdt_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
  import cdt_pkg::*;

  localparam dt_t DT_RESET = '{year: 14'd1, month: 4'd1, day: 5'd1,
                               hour: 5'd0, minute: 6'd0, second: 6'd0};

  // Stage advance: each stage moves when its downstream slot frees up
  logic adv1, adv2, adv3;
  logic in_acc;

  // Counter state
  dt_t  cur_q, cur_d;
  logic step_err;

  // Stage 1: snapshot of the new time
  logic s1_vld_q;
  dt_t  s1_dt_q;
  logic s1_err_q;

  // Stage 2: weekday sum
  logic        s2_vld_q;
  dt_t         s2_dt_q;
  logic        s2_err_q;
  logic [13:0] s2_sum_q;
  logic [13:0] wd_sum;

  // Stage 3: output register
  logic       s3_vld_q;
  dt_t        s3_dt_q;
  logic       s3_err_q;
  logic [2:0] s3_wday_q;
  logic [2:0] wday;

  assign adv3          = !s3_vld_q || m_axis_tready;
  assign adv2          = !s2_vld_q || adv3;
  assign adv1          = !s1_vld_q || adv2;
  assign s_axis_tready = adv1;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  cdt_step u_step (
    .cur_i  (cur_q),
    .req_i  (req_e'(s_axis_tuser)),
    .load_i (dt_t'(s_axis_tdata)),
    .nxt_o  (cur_d),
    .err_o  (step_err)
  );

  cdt_wday_sum u_wday_sum (
    .dt_i  (s1_dt_q),
    .sum_o (wd_sum)
  );

  cdt_mod7 u_mod7 (
    .x_i (s2_sum_q),
    .r_o (wday)
  );

  // Counter state, updated on every accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= DT_RESET;
    end else if (in_acc) begin
      cur_q <= cur_d;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      if (adv1) begin
        s1_vld_q <= in_acc;
      end
      if (adv2) begin
        s2_vld_q <= s1_vld_q;
      end
      if (adv3) begin
        s3_vld_q <= s2_vld_q;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_dt_q  <= cur_d;
      s1_err_q <= step_err;
    end
    if (adv2 && s1_vld_q) begin
      s2_dt_q  <= s1_dt_q;
      s2_err_q <= s1_err_q;
      s2_sum_q <= wd_sum;
    end
    if (adv3 && s2_vld_q) begin
      s3_dt_q   <= s2_dt_q;
      s3_err_q  <= s2_err_q;
      s3_wday_q <= wday;
    end
  end

  assign m_axis_tvalid = s3_vld_q;
  assign m_axis_tdata  = {5'd0, s3_wday_q, s3_dt_q};
  assign m_axis_tuser  = s3_err_q;

  // The counter never leaves the legal calendar range
  a_state_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q.year <= YEAR_LAST) && (cur_q.month >= 4'd1) && (cur_q.month <= 4'd12) &&
    (cur_q.day >= 5'd1) && (cur_q.hour < 5'd24) && (cur_q.minute < 6'd60) &&
    (cur_q.second < 6'd60))
    else $error("counter state out of calendar range");

  // No transaction, no change of time
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(cur_q))
    else $error("counter state changed without a transaction");

  // A rejected load leaves the time untouched
  a_err_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && step_err) |=> $stable(cur_q))
    else $error("rejected load modified the counter");

  // Weekday code is always a real day
  a_wday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_vld_q |-> (s3_wday_q != 3'd7))
    else $error("weekday out of range");

endmodule

@@ rtl/core/cdt_step.sv @@
// Next date/time for one transaction: tick forward, tick back or load.
// Depends on cdt_pkg.
`timescale 1ns / 1ps

module cdt_step (
  input  cdt_pkg::dt_t  cur_i,
  input  cdt_pkg::req_e req_i,
  input  cdt_pkg::dt_t  load_i,
  output cdt_pkg::dt_t  nxt_o,
  output logic          err_o
);
  import cdt_pkg::*;

  logic       cur_leap;
  logic       load_leap;
  logic [4:0] cur_dim;
  logic [3:0] prev_month;
  logic [4:0] prev_dim;
  logic       load_ok;

  assign cur_leap   = leap_year(cur_i.year);
  assign load_leap  = leap_year(load_i.year);
  assign cur_dim    = days_in(cur_i.month, cur_leap);
  // Going back from March lands in February of the same year
  assign prev_month = (cur_i.month <= 4'd1) ? 4'd12 : cur_i.month - 4'd1;
  assign prev_dim   = days_in(prev_month, cur_leap);

  assign load_ok = (load_i.year <= YEAR_LAST) &&
                   (load_i.day >= 5'd1) &&
                   (load_i.day <= days_in(load_i.month, load_leap)) &&
                   (load_i.hour < 5'd24) && (load_i.minute < 6'd60) &&
                   (load_i.second < 6'd60);

  always_comb begin
    nxt_o = cur_i;
    err_o = 1'b0;
    case (req_i)
      REQ_FWD: begin
        if (cur_i.second < 6'd59) begin
          nxt_o.second = cur_i.second + 6'd1;
        end else begin
          nxt_o.second = 6'd0;
          if (cur_i.minute < 6'd59) begin
            nxt_o.minute = cur_i.minute + 6'd1;
          end else begin
            nxt_o.minute = 6'd0;
            if (cur_i.hour < 5'd23) begin
              nxt_o.hour = cur_i.hour + 5'd1;
            end else begin
              nxt_o.hour = 5'd0;
              if (cur_i.day < cur_dim) begin
                nxt_o.day = cur_i.day + 5'd1;
              end else begin
                nxt_o.day = 5'd1;
                if (cur_i.month >= 4'd12) begin
                  nxt_o.month = 4'd1;
                  nxt_o.year  = (cur_i.year >= YEAR_LAST) ? 14'd0 : cur_i.year + 14'd1;
                end else begin
                  nxt_o.month = cur_i.month + 4'd1;
                end
              end
            end
          end
        end
      end
      REQ_BACK: begin
        if (cur_i.second > 6'd0) begin
          nxt_o.second = cur_i.second - 6'd1;
        end else begin
          nxt_o.second = 6'd59;
          if (cur_i.minute > 6'd0) begin
            nxt_o.minute = cur_i.minute - 6'd1;
          end else begin
            nxt_o.minute = 6'd59;
            if (cur_i.hour > 5'd0) begin
              nxt_o.hour = cur_i.hour - 5'd1;
            end else begin
              nxt_o.hour = 5'd23;
              if (cur_i.day > 5'd1) begin
                nxt_o.day = cur_i.day - 5'd1;
              end else begin
                nxt_o.month = prev_month;
                nxt_o.day   = prev_dim;
                if (cur_i.month <= 4'd1) begin
                  nxt_o.year = (cur_i.year == 14'd0) ? YEAR_LAST : cur_i.year - 14'd1;
                end
              end
            end
          end
        end
      end
      REQ_LOAD: begin
        if (load_ok) begin
          nxt_o = load_i;
        end else begin
          err_o = 1'b1;
        end
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

endmodule

@@ rtl/core/cdt_wday_sum.sv @@
// Weekday sum before the mod-7 reduction (Jan/Feb as months 13/14).
// Depends on cdt_pkg.
`timescale 1ns / 1ps

module cdt_wday_sum (
  input  cdt_pkg::dt_t dt_i,
  output logic [13:0]  sum_o
);
  import cdt_pkg::*;

  logic        early;
  logic [3:0]  adj_m;
  logic [13:0] adj_y;
  logic [27:0] prod;
  logic [8:0]  q100;
  logic [14:0] sum;

  assign early = (dt_i.month <= 4'd2);
  assign adj_m = early ? dt_i.month + 4'd12 : dt_i.month;
  assign adj_y = !early ? dt_i.year :
                 (dt_i.year == 14'd0) ? YEAR_LAST : dt_i.year - 14'd1;

  // y/100 by reciprocal; y/400 is then q100/4
  assign prod = {14'd0, adj_y} * 28'd5243;
  assign q100 = prod[27:19];

  assign sum = 15'(dt_i.day) + 15'({adj_m, 1'b0}) + 15'(WD_MONTH_TERM[adj_m]) +
               15'(adj_y) + 15'(adj_y >> 2) - 15'(q100) + 15'(q100 >> 2);

  assign sum_o = sum[13:0];

endmodule

@@ rtl/core/cdt_mod7.sv @@
// Remainder modulo 7 of the weekday sum via reciprocal multiply.
// No dependencies; standalone logic.
`timescale 1ns / 1ps

module cdt_mod7 (
  input  logic [13:0] x_i,
  output logic [2:0]  r_o
);

  logic [28:0] prod;
  logic [11:0] q;
  logic [14:0] q7;
  logic [13:0] r;

  // x/7 = (x * 18725) >> 17, exact for x < 43690
  assign prod = {15'd0, x_i} * 29'd18725;
  assign q    = prod[28:17];
  assign q7   = {q, 3'b000} - {3'b000, q};
  assign r    = x_i - q7[13:0];
  assign r_o  = r[2:0];

endmodule

@@ bench/tb_calendar_date_time_counter_unit.sv @@
// Self-checking testbench for calendar_date_time_counter_unit: directed corners,
// random carry/borrow sequences, random idling on both stream sides and an output hold-off.
// Depends on cdt_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb_calendar_date_time_counter_unit;
  import cdt_pkg::*;

  localparam int unsigned  RESET_CYCLES   = 9;
  localparam int unsigned  DRAIN_CYCLES   = 16;    // pipeline is three deep
  localparam int unsigned  HOLD_CYCLES    = 300;
  localparam int unsigned  WATCHDOG_LIMIT = 2000;
  localparam int unsigned  YEAR_COUNT     = 10000;
  localparam logic [1:0]   REQ_NONE       = 2'd3;  // unused request code, state kept

  // Expected result: date/time after the request, weekday and load rejection flag
  typedef struct packed {
    logic       load_err;
    logic [2:0] wday;
    dt_t        stamp;
  } reading_t;

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   s_axis_tvalid  = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata   = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser   = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;

  reading_t    pending_readings[$];
  dt_t         clock_now;          // predicted counter contents
  int unsigned error_cnt      = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  logic        hold_request   = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;

  calendar_date_time_counter_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin : clock_gen
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- calendar predictor

  function automatic bit leap_rule(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_rule(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Jan/Feb count as months 13/14 of the previous year; year 0 borrows from 9999
  function automatic logic [2:0] weekday_of_date(input dt_t t);
    int unsigned y, m, d;
    y = t.year;
    m = t.month;
    d = t.day;
    if (m <= 2) begin
      m += 12;
      y = (y == 0) ? YEAR_COUNT - 1 : y - 1;
    end
    return 3'((d + 2 * m + (3 * (m + 1)) / 5 + y + y / 4 - y / 100 + y / 400) % 7);
  endfunction

  function automatic dt_t stamp_of(input int unsigned y, input int unsigned mo,
                                   input int unsigned d, input int unsigned h,
                                   input int unsigned mi, input int unsigned s);
    dt_t t;
    t.year   = 14'(y);
    t.month  = 4'(mo);
    t.day    = 5'(d);
    t.hour   = 5'(h);
    t.minute = 6'(mi);
    t.second = 6'(s);
    return t;
  endfunction

  function automatic dt_t one_second_later(input dt_t t);
    dt_t n;
    n = t;
    if (n.second < 59) begin
      n.second = n.second + 6'd1;
    end else begin
      n.second = '0;
      if (n.minute < 59) begin
        n.minute = n.minute + 6'd1;
      end else begin
        n.minute = '0;
        if (n.hour < 23) begin
          n.hour = n.hour + 5'd1;
        end else begin
          n.hour = '0;
          if (n.day < month_length(n.year, n.month)) begin
            n.day = n.day + 5'd1;
          end else begin
            n.day = 5'd1;
            if (n.month >= 12) begin
              n.month = 4'd1;
              n.year  = (n.year == YEAR_LAST) ? 14'd0 : n.year + 14'd1;
            end else begin
              n.month = n.month + 4'd1;
            end
          end
        end
      end
    end
    return n;
  endfunction

  // Borrowing a day lands on the last day of the month before
  function automatic dt_t one_second_earlier(input dt_t t);
    dt_t n;
    n = t;
    if (n.second > 0) begin
      n.second = n.second - 6'd1;
    end else begin
      n.second = 6'd59;
      if (n.minute > 0) begin
        n.minute = n.minute - 6'd1;
      end else begin
        n.minute = 6'd59;
        if (n.hour > 0) begin
          n.hour = n.hour - 5'd1;
        end else begin
          n.hour = 5'd23;
          if (n.day > 1) begin
            n.day = n.day - 5'd1;
          end else begin
            if (n.month <= 1) begin
              n.month = 4'd12;
              n.year  = (n.year == 0) ? YEAR_LAST : n.year - 14'd1;
            end else begin
              n.month = n.month - 4'd1;
            end
            n.day = 5'(month_length(n.year, n.month));
          end
        end
      end
    end
    return n;
  endfunction

  function automatic bit load_fields_ok(input dt_t t);
    return t.year < YEAR_COUNT && t.month >= 1 && t.month <= 12 && t.day >= 1 &&
           t.day <= month_length(t.year, t.month) && t.hour < 24 && t.minute < 60 &&
           t.second < 60;
  endfunction

  // Updates clock_now for one request and returns the reading it should produce
  function automatic reading_t predict_reading(input logic [1:0] code, input dt_t ld);
    reading_t r;
    r.load_err = 1'b0;
    case (code)
      REQ_FWD:  clock_now = one_second_later(clock_now);
      REQ_BACK: clock_now = one_second_earlier(clock_now);
      REQ_LOAD: begin
        if (load_fields_ok(ld)) begin
          clock_now = ld;
        end else begin
          r.load_err = 1'b1;
        end
      end
      default: ;
    endcase
    r.stamp = clock_now;
    r.wday  = weekday_of_date(clock_now);
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  // Years biased toward the leap-rule and wrap corners
  function automatic int unsigned pick_year();
    case ($urandom_range(5))
      0:       return 0;
      1:       return YEAR_COUNT - 1;
      2:       return 400 * $urandom_range(24);
      3:       return 100 * $urandom_range(99);
      4:       return 4 * $urandom_range(2499);
      default: return $urandom_range(YEAR_COUNT - 1);
    endcase
  endfunction

  function automatic dt_t any_valid_stamp();
    int unsigned y, mo;
    y  = pick_year();
    mo = $urandom_range(1, 12);
    return stamp_of(y, mo, $urandom_range(1, month_length(y, mo)), $urandom_range(23),
                    $urandom_range(59), $urandom_range(59));
  endfunction

  // A few seconds short of a carry (ahead) or just past a borrow point (behind)
  function automatic dt_t edge_stamp(input bit ahead);
    dt_t         t;
    int unsigned len;
    t.year  = 14'(pick_year());
    t.month = 4'($urandom_range(1, 12));
    if ($urandom_range(7) == 0) begin
      t.year  = ahead ? YEAR_LAST : 14'd0;
      t.month = ahead ? 4'd12 : 4'd1;
    end
    len = month_length(t.year, t.month);
    if (ahead) begin
      t.day    = 5'(($urandom_range(3) == 0) ? $urandom_range(1, len) : len);
      t.hour   = ($urandom_range(3) == 0) ? 5'($urandom_range(23)) : 5'd23;
      t.minute = ($urandom_range(3) == 0) ? 6'($urandom_range(59)) : 6'd59;
      t.second = 6'(59 - $urandom_range(5));
    end else begin
      t.day    = 5'(($urandom_range(3) == 0) ? $urandom_range(1, len) : 1);
      t.hour   = ($urandom_range(3) == 0) ? 5'($urandom_range(23)) : 5'd0;
      t.minute = ($urandom_range(3) == 0) ? 6'($urandom_range(59)) : 6'd0;
      t.second = 6'($urandom_range(5));
    end
    return t;
  endfunction

  // Valid date/time with exactly one field pushed out of range
  function automatic dt_t broken_stamp();
    dt_t t;
    t = any_valid_stamp();
    case ($urandom_range(5))
      0: t.year   = 14'($urandom_range(YEAR_COUNT, 16383));
      1: t.month  = ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
      2: t.day    = ($urandom_range(1) == 0 || month_length(t.year, t.month) == 31) ? 5'd0 :
                    5'($urandom_range(month_length(t.year, t.month) + 1, 31));
      3: t.hour   = 5'($urandom_range(24, 31));
      4: t.minute = 6'($urandom_range(60, 63));
      default: t.second = 6'($urandom_range(60, 63));
    endcase
    return t;
  endfunction

  // Called at a rising edge; returns at the edge that accepts the transaction.
  // tvalid is left high so a back-to-back transaction does not drop it.
  task automatic send_item(input logic [1:0] code, input dt_t ld);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ld;
    s_axis_tuser  <= code;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_readings.push_back(predict_reading(code, ld));
  endtask

  task automatic send_tick(input bit ahead);
    send_item(ahead ? REQ_FWD : REQ_BACK, dt_t'({$urandom, $urandom}));
  endtask

  // Drop tvalid and let every outstanding reading drain
  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_readings.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic note_error(input string msg);
    error_cnt++;
    if (error_cnt <= 10) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
  endtask

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      note_error($sformatf("%s expected %0d actual %0d", fname, want, got));
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_corners();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_item(REQ_FWD, '0);                                 // out of reset state
    send_item(REQ_BACK, '0);
    send_item(REQ_BACK, '0);                                // into year 0
    send_item(REQ_LOAD, stamp_of(9999, 12, 31, 23, 59, 59));
    send_item(REQ_FWD, '0);                                 // wrap forward to year 0
    send_item(REQ_BACK, '0);                                // wrap back to 9999
    send_item(REQ_LOAD, '1);                                // every field out of range
    send_item(REQ_LOAD, stamp_of(2000, 2, 28, 23, 59, 59));
    send_item(REQ_FWD, '0);                                 // leap by the 400 rule
    send_item(REQ_LOAD, stamp_of(2000, 3, 1, 0, 0, 0));
    send_item(REQ_BACK, '0);                                // borrow into Feb 29
    send_item(REQ_LOAD, stamp_of(1900, 2, 29, 0, 0, 0));    // not leap by the 100 rule
    send_item(REQ_LOAD, stamp_of(2024, 2, 29, 12, 30, 45));
    send_item(REQ_LOAD, stamp_of(2023, 2, 29, 0, 0, 0));
    send_item(REQ_LOAD, stamp_of(0, 2, 29, 0, 0, 0));       // year 0 is leap
    send_item(REQ_BACK, '0);
    send_item(REQ_LOAD, stamp_of(2021, 0, 10, 1, 2, 3));
    send_item(REQ_LOAD, stamp_of(2021, 5, 0, 1, 2, 3));
    send_item(REQ_LOAD, stamp_of(2021, 4, 31, 1, 2, 3));
    send_item(REQ_LOAD, stamp_of(2021, 4, 30, 23, 59, 59));
    send_item(REQ_FWD, '0);                                 // 30-day month carry
    send_item(REQ_NONE, '1);                                // unused code, no change
    send_item(REQ_LOAD, stamp_of(10000, 1, 1, 0, 0, 0));
    send_item(REQ_LOAD, stamp_of(2021, 6, 15, 24, 0, 0));
    send_item(REQ_LOAD, stamp_of(2021, 6, 15, 0, 60, 0));
    send_item(REQ_LOAD, stamp_of(2021, 6, 15, 0, 0, 60));
    settle_idle();
  endtask

  // Mostly load-near-a-boundary-then-tick runs, plus noise and rejected loads
  task automatic test_random_traffic(input int unsigned n_items,
                                     input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    int unsigned sent;
    int unsigned run;
    bit          ahead;
    sent           = 0;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0: begin
          send_item(2'($urandom_range(3)), dt_t'({$urandom, $urandom}));
          sent++;
        end
        1: begin
          send_item(REQ_LOAD, broken_stamp());
          send_tick(1'($urandom_range(1)));
          sent += 2;
        end
        2: begin
          send_item(REQ_LOAD, any_valid_stamp());
          sent++;
        end
        default: begin
          ahead = 1'($urandom_range(1));
          run   = $urandom_range(2, 12);
          send_item(REQ_LOAD, edge_stamp(ahead));
          repeat (run) send_tick(($urandom_range(9) == 0) ? !ahead : ahead);
          sent += run + 1;
        end
      endcase
    end
    settle_idle();
  endtask

  // Output side stops for a long stretch while transactions keep coming
  task automatic test_output_hold_off();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_request <= 1'b1;
    @(posedge clk_i);
    hold_request <= 1'b0;
    send_item(REQ_LOAD, edge_stamp(1'b1));
    repeat (40) send_tick($urandom_range(3) != 0);
    settle_idle();
  endtask

  // ---------------------------------------------------------------- output side

  always @(posedge clk_i) begin : sink_ready_gen
    if (hold_request) begin
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_checker
    reading_t want;
    dt_t      got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[39:0];
      if (pending_readings.size() == 0) begin
        note_error($sformatf("unexpected result tdata=%h tuser=%b", m_axis_tdata,
                             m_axis_tuser));
      end else begin
        want = pending_readings.pop_front();
        check_field("year", want.stamp.year, got.year);
        check_field("month", want.stamp.month, got.month);
        check_field("day", want.stamp.day, got.day);
        check_field("hour", want.stamp.hour, got.hour);
        check_field("minute", want.stamp.minute, got.minute);
        check_field("second", want.stamp.second, got.second);
        check_field("weekday", want.wday, m_axis_tdata[42:40]);
        check_field("pad", 0, m_axis_tdata[47:43]);
        check_field("load_error", want.load_err, m_axis_tuser[0]);
      end
    end
  end

  // Ends the run when neither side moves for too long
  always @(posedge clk_i) begin : stall_watchdog
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("calendar_date_time_counter_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : test_sequence
    clock_now = stamp_of(1, 1, 1, 0, 0, 0);
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_corners();
    test_random_traffic(240, 0, 0);
    test_random_traffic(240, 53, 0);
    test_random_traffic(240, 0, 53);
    test_output_hold_off();
    test_random_traffic(240, 14, 14);
    if (pending_readings.size() != 0) begin
      note_error($sformatf("%0d readings never arrived", pending_readings.size()));
    end
    if (error_cnt == 0) begin
      $display("calendar_date_time_counter_unit regression: pass");
    end else begin
      $display("calendar_date_time_counter_unit regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/cdt_pkg.sv
rtl/core/cdt_step.sv
rtl/core/cdt_wday_sum.sv
rtl/core/cdt_mod7.sv
rtl/core/calendar_date_time_counter_unit.sv
bench/tb_calendar_date_time_counter_unit.sv
